// File: design/explicit_free_list_allocator_core_assert.svh
// ----------------------------------------------------------------------------
// explicit_free_list_allocator_core_assert.svh
// Assertion macros for the heap allocator core.
// ----------------------------------------------------------------------------
`ifndef EXPLICIT_FREE_LIST_ALLOCATOR_CORE_ASSERT_SVH
`define EXPLICIT_FREE_LIST_ALLOCATOR_CORE_ASSERT_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define EFLA_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("allocator assertion failed");
// next-cycle implication
`define EFLA_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("allocator assertion failed");
`else
`define EFLA_ASSERT_IMPL(lbl, clk, rstn, ante, cons)
`define EFLA_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

// File: design/efla_pkg.sv
// ----------------------------------------------------------------------------
// efla_pkg
// Shared constants, step codes and controller/datapath types.
// ----------------------------------------------------------------------------
package efla_pkg;

    localparam int HEAP_BYTES_DEF = 65536;
    localparam int CHUNK_RESET    = 4096;
    localparam int CFG_W          = 17;
    localparam int SIZE_W         = 17;
    localparam int ADDR_W         = 16;
    localparam int ASIZE_W        = 18;
    localparam int ST_W           = 6;

    localparam logic REQ_ALLOC = 1'b0;
    localparam logic REQ_FREE  = 1'b1;

    localparam logic [1:0] MODE_INIT  = 2'd0;
    localparam logic [1:0] MODE_ALLOC = 2'd1;
    localparam logic [1:0] MODE_FREE  = 2'd2;

    // unlink return points
    localparam logic [1:0] RET_MN = 2'd0;
    localparam logic [1:0] RET_MP = 2'd1;
    localparam logic [1:0] RET_PL = 2'd2;

    typedef logic [ST_W-1:0] t_state;

    localparam t_state S_IDLE  = 6'd0;
    localparam t_state S_INIT0 = 6'd1;
    localparam t_state S_INIT1 = 6'd2;
    localparam t_state S_INIT2 = 6'd3;
    localparam t_state S_INIT3 = 6'd4;
    localparam t_state S_A_CHK = 6'd5;
    localparam t_state S_FAIL  = 6'd6;
    localparam t_state S_W_CHK = 6'd7;
    localparam t_state S_W_SZ  = 6'd8;
    localparam t_state S_W_NX  = 6'd9;
    localparam t_state S_G_SET = 6'd10;
    localparam t_state S_G_CHK = 6'd11;
    localparam t_state S_G_W0  = 6'd12;
    localparam t_state S_G_W1  = 6'd13;
    localparam t_state S_G_W2  = 6'd14;
    localparam t_state S_M0    = 6'd15;
    localparam t_state S_M1    = 6'd16;
    localparam t_state S_M2    = 6'd17;
    localparam t_state S_M3    = 6'd18;
    localparam t_state S_M_NXT = 6'd19;
    localparam t_state S_M4    = 6'd20;
    localparam t_state S_M5    = 6'd21;
    localparam t_state S_M6    = 6'd22;
    localparam t_state S_M7    = 6'd23;
    localparam t_state S_I0    = 6'd24;
    localparam t_state S_I1    = 6'd25;
    localparam t_state S_I2    = 6'd26;
    localparam t_state S_U0    = 6'd27;
    localparam t_state S_U1    = 6'd28;
    localparam t_state S_U2    = 6'd29;
    localparam t_state S_U3    = 6'd30;
    localparam t_state S_P_RD  = 6'd31;
    localparam t_state S_P_SZ  = 6'd32;
    localparam t_state S_P_S1  = 6'd33;
    localparam t_state S_P_S2  = 6'd34;
    localparam t_state S_P_S3  = 6'd35;
    localparam t_state S_P_S4  = 6'd36;
    localparam t_state S_P_S5  = 6'd37;
    localparam t_state S_P_S6  = 6'd38;
    localparam t_state S_P_S7  = 6'd39;
    localparam t_state S_P_S8  = 6'd40;
    localparam t_state S_P_S9  = 6'd41;
    localparam t_state S_P_NS  = 6'd42;
    localparam t_state S_P_NS2 = 6'd43;
    localparam t_state S_F_CHK = 6'd44;
    localparam t_state S_F_HD  = 6'd45;
    localparam t_state S_F_FT  = 6'd46;

    typedef struct packed {
        t_state op;
        logic   accept;
    } t_cmd;

    typedef struct packed {
        logic zero_size;
        logic walk_end;
        logic fit;
        logic grow_fail;
        logic next_free;
        logic prev_free;
        logic split;
        logic free_bad;
        logic hdr_bad;
    } t_stat;

    // growth size: whole words, odd word count rounded up to even
    function automatic logic [31:0] gsize(input logic [ASIZE_W-1:0] bytes);
        logic [16:0] words;
        words = {1'b0, bytes[17:2]} + {16'b0, bytes[2]};
        return {13'b0, words, 2'b00};
    endfunction

endpackage

// File: design/efla_ram.sv
// ----------------------------------------------------------------------------
// efla_ram
// Single-port RAM, one access per cycle, registered read data.
// ----------------------------------------------------------------------------
module efla_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16384
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: design/efla_ctrl.sv
// ----------------------------------------------------------------------------
// efla_ctrl
// Step sequencer: walks init, alloc, free, grow, merge, unlink and place.
// ----------------------------------------------------------------------------
module efla_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  logic            i_req_type,
    input  efla_pkg::t_stat i_stat,
    output efla_pkg::t_cmd  o_cmd,
    output logic            o_busy,
    output logic            o_valid
);

    efla_pkg::t_state r_state, n_state;
    logic [1:0]       r_mode, n_mode;
    logic [1:0]       r_ret, n_ret;
    logic             r_valid, n_valid;
    logic             accept;

    assign accept = i_start && (r_state == efla_pkg::S_IDLE);

    always_comb begin
        n_state = r_state;
        n_mode  = r_mode;
        n_ret   = r_ret;
        n_valid = 1'b0;
        unique case (r_state)
            efla_pkg::S_IDLE: begin
                if (accept) begin
                    if (i_req_type == efla_pkg::REQ_FREE) begin
                        n_mode  = efla_pkg::MODE_FREE;
                        n_state = efla_pkg::S_F_CHK;
                    end else begin
                        n_mode  = efla_pkg::MODE_ALLOC;
                        n_state = efla_pkg::S_A_CHK;
                    end
                end
            end
            efla_pkg::S_INIT0: n_state = efla_pkg::S_INIT1;
            efla_pkg::S_INIT1: n_state = efla_pkg::S_INIT2;
            efla_pkg::S_INIT2: n_state = efla_pkg::S_INIT3;
            efla_pkg::S_INIT3: n_state = efla_pkg::S_G_CHK;
            efla_pkg::S_A_CHK: begin
                n_state = i_stat.zero_size ? efla_pkg::S_FAIL : efla_pkg::S_W_CHK;
            end
            efla_pkg::S_FAIL: begin
                n_state = efla_pkg::S_IDLE;
                n_valid = 1'b1;
            end
            efla_pkg::S_W_CHK: begin
                n_state = i_stat.walk_end ? efla_pkg::S_G_SET : efla_pkg::S_W_SZ;
            end
            efla_pkg::S_W_SZ: begin
                n_state = i_stat.fit ? efla_pkg::S_P_RD : efla_pkg::S_W_NX;
            end
            efla_pkg::S_W_NX: n_state = efla_pkg::S_W_CHK;
            efla_pkg::S_G_SET: n_state = efla_pkg::S_G_CHK;
            efla_pkg::S_G_CHK: begin
                if (!i_stat.grow_fail) begin
                    n_state = efla_pkg::S_G_W0;
                end else if (r_mode == efla_pkg::MODE_INIT) begin
                    n_state = efla_pkg::S_IDLE;
                end else begin
                    n_state = efla_pkg::S_FAIL;
                end
            end
            efla_pkg::S_G_W0: n_state = efla_pkg::S_G_W1;
            efla_pkg::S_G_W1: n_state = efla_pkg::S_G_W2;
            efla_pkg::S_G_W2: n_state = efla_pkg::S_M0;
            efla_pkg::S_M0: n_state = efla_pkg::S_M1;
            efla_pkg::S_M1: n_state = efla_pkg::S_M2;
            efla_pkg::S_M2: n_state = efla_pkg::S_M3;
            efla_pkg::S_M3: begin
                if (i_stat.next_free) begin
                    n_ret   = efla_pkg::RET_MN;
                    n_state = efla_pkg::S_U0;
                end else begin
                    n_state = efla_pkg::S_M4;
                end
            end
            efla_pkg::S_M_NXT: n_state = efla_pkg::S_M4;
            efla_pkg::S_M4: begin
                if (i_stat.prev_free) begin
                    n_ret   = efla_pkg::RET_MP;
                    n_state = efla_pkg::S_U0;
                end else begin
                    n_state = efla_pkg::S_M6;
                end
            end
            efla_pkg::S_M5: n_state = efla_pkg::S_M6;
            efla_pkg::S_M6: n_state = efla_pkg::S_M7;
            efla_pkg::S_M7: n_state = efla_pkg::S_I0;
            efla_pkg::S_I0: n_state = efla_pkg::S_I1;
            efla_pkg::S_I1: n_state = efla_pkg::S_I2;
            efla_pkg::S_I2: begin
                if (r_mode == efla_pkg::MODE_ALLOC) begin
                    n_state = efla_pkg::S_P_RD;
                end else begin
                    n_state = efla_pkg::S_IDLE;
                    n_valid = (r_mode == efla_pkg::MODE_FREE);
                end
            end
            efla_pkg::S_U0: n_state = efla_pkg::S_U1;
            efla_pkg::S_U1: n_state = efla_pkg::S_U2;
            efla_pkg::S_U2: n_state = efla_pkg::S_U3;
            efla_pkg::S_U3: begin
                case (r_ret)
                    efla_pkg::RET_MN: n_state = efla_pkg::S_M_NXT;
                    efla_pkg::RET_MP: n_state = efla_pkg::S_M5;
                    default:          n_state = efla_pkg::S_P_NS;
                endcase
            end
            efla_pkg::S_P_RD: n_state = efla_pkg::S_P_SZ;
            efla_pkg::S_P_SZ: begin
                if (i_stat.split) begin
                    n_state = efla_pkg::S_P_S1;
                end else begin
                    n_ret   = efla_pkg::RET_PL;
                    n_state = efla_pkg::S_U0;
                end
            end
            efla_pkg::S_P_S1: n_state = efla_pkg::S_P_S2;
            efla_pkg::S_P_S2: n_state = efla_pkg::S_P_S3;
            efla_pkg::S_P_S3: n_state = efla_pkg::S_P_S4;
            efla_pkg::S_P_S4: n_state = efla_pkg::S_P_S5;
            efla_pkg::S_P_S5: n_state = efla_pkg::S_P_S6;
            efla_pkg::S_P_S6: n_state = efla_pkg::S_P_S7;
            efla_pkg::S_P_S7: n_state = efla_pkg::S_P_S8;
            efla_pkg::S_P_S8: n_state = efla_pkg::S_P_S9;
            efla_pkg::S_P_S9, efla_pkg::S_P_NS2: begin
                n_state = efla_pkg::S_IDLE;
                n_valid = 1'b1;
            end
            efla_pkg::S_P_NS: n_state = efla_pkg::S_P_NS2;
            efla_pkg::S_F_CHK: begin
                if (i_stat.free_bad) begin
                    n_state = efla_pkg::S_IDLE;
                    n_valid = 1'b1;
                end else begin
                    n_state = efla_pkg::S_F_HD;
                end
            end
            efla_pkg::S_F_HD: begin
                if (i_stat.hdr_bad) begin
                    n_state = efla_pkg::S_IDLE;
                    n_valid = 1'b1;
                end else begin
                    n_state = efla_pkg::S_F_FT;
                end
            end
            efla_pkg::S_F_FT: n_state = efla_pkg::S_M0;
            default: n_state = efla_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= efla_pkg::S_INIT0;
            r_mode  <= efla_pkg::MODE_INIT;
            r_ret   <= efla_pkg::RET_MN;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_mode  <= n_mode;
            r_ret   <= n_ret;
            r_valid <= n_valid;
        end
    end

    assign o_cmd.op     = r_state;
    assign o_cmd.accept = accept;
    assign o_busy       = (r_state != efla_pkg::S_IDLE);
    assign o_valid      = r_valid;

endmodule

// File: design/efla_dp.sv
// ----------------------------------------------------------------------------
// efla_dp
// Datapath: heap pointers, block sizes, list links and heap memory access.
// ----------------------------------------------------------------------------
module efla_dp #(
    parameter int HEAP_BYTES = efla_pkg::HEAP_BYTES_DEF,
    parameter int IW         = $clog2(HEAP_BYTES) - 2
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  efla_pkg::t_cmd              i_cmd,
    input  logic [efla_pkg::SIZE_W-1:0] i_req_size,
    input  logic [efla_pkg::ADDR_W-1:0] i_block_addr,
    input  logic                        i_cfg_we,
    input  logic [efla_pkg::CFG_W-1:0]  i_cfg_wdata,
    output efla_pkg::t_stat             o_stat,
    output logic [efla_pkg::ADDR_W-1:0] o_result_addr,
    output logic                        o_status,
    output logic                        o_mem_we,
    output logic [IW-1:0]               o_mem_addr,
    output logic [31:0]                 o_mem_wdata,
    input  logic [31:0]                 i_mem_rdata
);

    localparam int AW    = IW + 2;
    localparam int BRK_W = AW + 1;
    localparam int NW16  = HEAP_BYTES / 16;
    localparam int CNT_W = $clog2(NW16 + 2);

    logic [31:0]                   r_head;
    logic [BRK_W-1:0]              r_brk;
    logic [efla_pkg::CFG_W-1:0]    r_chunk;
    logic [efla_pkg::SIZE_W-1:0]   r_req_size;
    logic [efla_pkg::ADDR_W-1:0]   r_block_addr;
    logic [efla_pkg::ASIZE_W-1:0]  r_asize;
    logic [31:0]                   r_p;
    logic [CNT_W-1:0]              r_cnt;
    logic [31:0]                   r_bp;
    logic [31:0]                   r_size;
    logic [31:0]                   r_psize;
    logic                          r_pfree;
    logic [31:0]                   r_nsize;
    logic [31:0]                   r_x;
    logic [31:0]                   r_nx;
    logic [31:0]                   r_pv;
    logic [31:0]                   r_rem;
    logic [31:0]                   r_rbp;
    logic [efla_pkg::ADDR_W-1:0]   r_res_addr;
    logic                          r_status;

    logic [31:0]                   rd_sz;
    logic [31:0]                   asize32;
    logic [31:0]                   rem_c;
    logic [32:0]                   gsum;
    logic [efla_pkg::ASIZE_W-1:0]  asize_c;
    logic [efla_pkg::ASIZE_W-1:0]  gbytes;
    logic [31:0]                   mem_a;

    assign rd_sz   = {i_mem_rdata[31:3], 3'b000};
    assign asize32 = 32'(r_asize);
    assign rem_c   = rd_sz - asize32;
    assign gsum    = 33'(r_brk) + 33'(r_size);
    assign gbytes  = (r_asize > 18'(r_chunk)) ? r_asize : 18'(r_chunk);

    // sizes up to 8 take the minimum block; others add header/footer and align
    always_comb begin
        if (i_req_size <= 17'd8) begin
            asize_c = 18'd16;
        end else begin
            asize_c = (18'(i_req_size) + 18'd16) & ~18'd7;
        end
    end

    always_comb begin
        o_stat.zero_size = (r_req_size == '0);
        o_stat.walk_end  = (r_p == 32'd0) || (r_cnt > CNT_W'(NW16));
        o_stat.fit       = (rd_sz >= asize32);
        o_stat.grow_fail = (r_size == 32'd0) || (gsum > 33'(HEAP_BYTES));
        o_stat.next_free = !i_mem_rdata[0] && (rd_sz != 32'd0);
        o_stat.prev_free = r_pfree;
        o_stat.split     = (rem_c >= 32'd16);
        o_stat.free_bad  = (r_block_addr[2:0] != 3'd0) || (r_block_addr < 16'd16)
                           || (32'(r_block_addr) >= 32'(r_brk));
        o_stat.hdr_bad   = !i_mem_rdata[0] || (rd_sz < 32'd16);
    end

    // memory request per step; byte addresses wrap into the word array
    always_comb begin
        o_mem_we    = 1'b0;
        mem_a       = 32'd0;
        o_mem_wdata = 32'd0;
        unique case (i_cmd.op)
            efla_pkg::S_INIT0: begin o_mem_we = 1'b1; mem_a = 32'd0; end
            efla_pkg::S_INIT1: begin
                o_mem_we = 1'b1; mem_a = 32'd4; o_mem_wdata = 32'd9;
            end
            efla_pkg::S_INIT2: begin
                o_mem_we = 1'b1; mem_a = 32'd8; o_mem_wdata = 32'd9;
            end
            efla_pkg::S_INIT3: begin
                o_mem_we = 1'b1; mem_a = 32'd12; o_mem_wdata = 32'd1;
            end
            efla_pkg::S_W_CHK: mem_a = r_p - 32'd4;
            efla_pkg::S_W_SZ:  mem_a = r_p;
            efla_pkg::S_G_W0: begin
                o_mem_we = 1'b1; mem_a = r_bp - 32'd4; o_mem_wdata = r_size;
            end
            efla_pkg::S_G_W1: begin
                o_mem_we = 1'b1; mem_a = r_bp + r_size - 32'd8; o_mem_wdata = r_size;
            end
            efla_pkg::S_G_W2: begin
                o_mem_we = 1'b1; mem_a = r_bp + r_size - 32'd4; o_mem_wdata = 32'd1;
            end
            efla_pkg::S_M0: mem_a = r_bp - 32'd4;
            efla_pkg::S_M1: mem_a = r_bp - 32'd8;
            efla_pkg::S_M2: mem_a = r_bp + r_size - 32'd4;
            efla_pkg::S_M6: begin
                o_mem_we = 1'b1; mem_a = r_bp - 32'd4; o_mem_wdata = r_size;
            end
            efla_pkg::S_M7: begin
                o_mem_we = 1'b1; mem_a = r_bp + r_size - 32'd8; o_mem_wdata = r_size;
            end
            efla_pkg::S_I0: begin
                o_mem_we = 1'b1; mem_a = r_bp; o_mem_wdata = r_head;
            end
            efla_pkg::S_I1: begin
                o_mem_we = 1'b1; mem_a = r_bp + 32'd4;
            end
            efla_pkg::S_I2: begin
                o_mem_we = (r_head != 32'd0); mem_a = r_head + 32'd4; o_mem_wdata = r_bp;
            end
            efla_pkg::S_U0: mem_a = r_x;
            efla_pkg::S_U1: mem_a = r_x + 32'd4;
            efla_pkg::S_U2: begin
                // read data here is the prev link
                o_mem_we = (i_mem_rdata != 32'd0); mem_a = i_mem_rdata; o_mem_wdata = r_nx;
            end
            efla_pkg::S_U3: begin
                o_mem_we = (r_nx != 32'd0); mem_a = r_nx + 32'd4; o_mem_wdata = r_pv;
            end
            efla_pkg::S_P_RD: mem_a = r_bp - 32'd4;
            efla_pkg::S_P_SZ: mem_a = r_bp;
            efla_pkg::S_P_S1: mem_a = r_bp + 32'd4;
            efla_pkg::S_P_S2: begin
                o_mem_we = 1'b1; mem_a = r_bp - 32'd4; o_mem_wdata = asize32 | 32'd1;
            end
            efla_pkg::S_P_S3: begin
                o_mem_we = 1'b1; mem_a = r_bp + asize32 - 32'd8;
                o_mem_wdata = asize32 | 32'd1;
            end
            efla_pkg::S_P_S4: begin
                o_mem_we = 1'b1; mem_a = r_rbp - 32'd4; o_mem_wdata = r_rem;
            end
            efla_pkg::S_P_S5: begin
                o_mem_we = 1'b1; mem_a = r_rbp + r_rem - 32'd8; o_mem_wdata = r_rem;
            end
            efla_pkg::S_P_S6: begin
                o_mem_we = 1'b1; mem_a = r_rbp; o_mem_wdata = r_nx;
            end
            efla_pkg::S_P_S7: begin
                o_mem_we = 1'b1; mem_a = r_rbp + 32'd4; o_mem_wdata = r_pv;
            end
            efla_pkg::S_P_S8: begin
                o_mem_we = (r_nx != 32'd0); mem_a = r_nx + 32'd4; o_mem_wdata = r_rbp;
            end
            efla_pkg::S_P_S9: begin
                o_mem_we = (r_pv != 32'd0); mem_a = r_pv; o_mem_wdata = r_rbp;
            end
            efla_pkg::S_P_NS: begin
                o_mem_we = 1'b1; mem_a = r_bp - 32'd4; o_mem_wdata = r_size | 32'd1;
            end
            efla_pkg::S_P_NS2: begin
                o_mem_we = 1'b1; mem_a = r_bp + r_size - 32'd8;
                o_mem_wdata = r_size | 32'd1;
            end
            efla_pkg::S_F_CHK: mem_a = 32'(r_block_addr) - 32'd4;
            efla_pkg::S_F_HD: begin
                o_mem_we = !o_stat.hdr_bad; mem_a = r_bp - 32'd4; o_mem_wdata = rd_sz;
            end
            efla_pkg::S_F_FT: begin
                o_mem_we = 1'b1; mem_a = r_bp + r_size - 32'd8; o_mem_wdata = r_size;
            end
            default: mem_a = 32'd0;
        endcase
    end

    assign o_mem_addr = mem_a[AW-1:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= 32'd0;
            r_brk   <= BRK_W'(16);
            r_chunk <= efla_pkg::CFG_W'(efla_pkg::CHUNK_RESET);
        end else begin
            if (i_cfg_we) begin
                r_chunk <= i_cfg_wdata;
            end
            unique case (i_cmd.op)
                efla_pkg::S_G_W2: r_brk <= r_brk + r_size[BRK_W-1:0];
                efla_pkg::S_I2:   r_head <= r_bp;
                efla_pkg::S_U2: begin
                    if (i_mem_rdata == 32'd0) begin
                        r_head <= r_nx;
                    end
                end
                efla_pkg::S_P_S9: begin
                    if (r_pv == 32'd0) begin
                        r_head <= r_rbp;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (i_cmd.op)
            efla_pkg::S_IDLE: begin
                if (i_cmd.accept) begin
                    r_req_size   <= i_req_size;
                    r_block_addr <= i_block_addr;
                    r_asize      <= asize_c;
                    r_res_addr   <= '0;
                    r_status     <= 1'b0;
                end
            end
            efla_pkg::S_INIT3: r_size <= efla_pkg::gsize(18'(efla_pkg::CHUNK_RESET));
            efla_pkg::S_A_CHK: begin
                r_p   <= r_head;
                r_cnt <= '0;
            end
            efla_pkg::S_FAIL: r_status <= 1'b1;
            efla_pkg::S_W_SZ: begin
                if (o_stat.fit) begin
                    r_bp <= r_p;
                end
            end
            efla_pkg::S_W_NX: begin
                r_p   <= i_mem_rdata;
                r_cnt <= r_cnt + 1'b1;
            end
            efla_pkg::S_G_SET: r_size <= efla_pkg::gsize(gbytes);
            efla_pkg::S_G_CHK: r_bp <= 32'(r_brk);
            efla_pkg::S_M1: r_size <= rd_sz;
            efla_pkg::S_M2: begin
                r_psize <= rd_sz;
                r_pfree <= !i_mem_rdata[0] && (rd_sz != 32'd0) && (rd_sz < r_bp);
            end
            efla_pkg::S_M3: begin
                r_nsize <= rd_sz;
                r_x     <= r_bp + r_size;
            end
            efla_pkg::S_M_NXT: r_size <= r_size + r_nsize;
            efla_pkg::S_M4: r_x <= r_bp - r_psize;
            efla_pkg::S_M5: begin
                r_bp   <= r_bp - r_psize;
                r_size <= r_size + r_psize;
            end
            efla_pkg::S_U1: r_nx <= i_mem_rdata;
            efla_pkg::S_U2: r_pv <= i_mem_rdata;
            efla_pkg::S_P_SZ: begin
                r_size <= rd_sz;
                r_rem  <= rem_c;
                r_rbp  <= r_bp + asize32;
                r_x    <= r_bp;
            end
            efla_pkg::S_P_S1: r_nx <= i_mem_rdata;
            efla_pkg::S_P_S2: r_pv <= i_mem_rdata;
            efla_pkg::S_P_S9, efla_pkg::S_P_NS2: r_res_addr <= r_bp[15:0];
            efla_pkg::S_F_CHK: r_bp <= 32'(r_block_addr);
            efla_pkg::S_F_HD: r_size <= rd_sz;
            default: begin
            end
        endcase
    end

    assign o_result_addr = r_res_addr;
    assign o_status      = r_status;

endmodule

// File: design/explicit_free_list_allocator_core.sv
// ----------------------------------------------------------------------------
// explicit_free_list_allocator_core
// First-fit heap allocator with boundary tags and a LIFO free list.
// ----------------------------------------------------------------------------
// One request at a time: busy is high from the accepting edge until the
// cycle the result strobe o_valid rises, and the result is shown for exactly
// one cycle. The receiver cannot stall it, so it must be captured then.
// Every step is one access to the single-port heap RAM. A free stops with
// no heap write when the address is rejected or the header is not an
// allocated block, and otherwise coalesces with no, one or both neighbors.
// An allocate walks the free list first-fit and places the block whole or
// splits it. When no element fits, the heap grows, and the new space merges
// with a free tail block if there is one. A zero size fails before any walk,
// a full heap after the walk. After reset the prologue, epilogue and first
// free chunk are built with busy high. HEAP_BYTES must be a power of two.
// ----------------------------------------------------------------------------
module explicit_free_list_allocator_core #(
    parameter int HEAP_BYTES = efla_pkg::HEAP_BYTES_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic                        i_req_type,
    input  logic [efla_pkg::SIZE_W-1:0] i_req_size,
    input  logic [efla_pkg::ADDR_W-1:0] i_block_addr,
    input  logic                        i_cfg_we,
    input  logic [efla_pkg::CFG_W-1:0]  i_cfg_wdata,
    output logic                        o_valid,
    output logic [efla_pkg::ADDR_W-1:0] o_result_addr,
    output logic                        o_status
);

`include "explicit_free_list_allocator_core_assert.svh"

    localparam int IW    = $clog2(HEAP_BYTES) - 2;
    localparam int DEPTH = HEAP_BYTES / 4;

    efla_pkg::t_cmd  cmd;
    efla_pkg::t_stat stat;
    logic            mem_we;
    logic [IW-1:0]   mem_addr;
    logic [31:0]     mem_wdata;
    logic [31:0]     mem_rdata;

    efla_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (start),
        .i_req_type (i_req_type),
        .i_stat     (stat),
        .o_cmd      (cmd),
        .o_busy     (busy),
        .o_valid    (o_valid)
    );

    efla_dp #(
        .HEAP_BYTES (HEAP_BYTES),
        .IW         (IW)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_req_size    (i_req_size),
        .i_block_addr  (i_block_addr),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .o_stat        (stat),
        .o_result_addr (o_result_addr),
        .o_status      (o_status),
        .o_mem_we      (mem_we),
        .o_mem_addr    (mem_addr),
        .o_mem_wdata   (mem_wdata),
        .i_mem_rdata   (mem_rdata)
    );

    efla_ram #(
        .WIDTH (32),
        .DEPTH (DEPTH)
    ) u_heap (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_addr  (mem_addr),
        .i_wdata (mem_wdata),
        .o_rdata (mem_rdata)
    );

    `EFLA_ASSERT_IMPL(a_valid_when_idle, i_clk, i_rst_n, o_valid, !busy)
    `EFLA_ASSERT_NEXT(a_accept_goes_busy, i_clk, i_rst_n, start && !busy, busy)
    `EFLA_ASSERT_NEXT(a_valid_one_cycle, i_clk, i_rst_n, o_valid, !o_valid)
    `EFLA_ASSERT_IMPL(a_fail_zero_addr, i_clk, i_rst_n, o_valid && o_status, o_result_addr == '0)

endmodule
